[sv/go_back_n_sender_window_unit_defines.svh]
// ----------------------------------------------------------------------------
// Go-Back-N sender window: assertion macros
// Shared concurrent assertion shorthands, clocked on clk, disabled in rst.
// ----------------------------------------------------------------------------
`ifndef GO_BACK_N_SENDER_WINDOW_UNIT_DEFINES_SVH
`define GO_BACK_N_SENDER_WINDOW_UNIT_DEFINES_SVH

// same-cycle implication
`define GBN_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// next-cycle implication
`define GBN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

[sv/gbn_pkg.sv]
// ----------------------------------------------------------------------------
// gbn_pkg
// Types, codes and fixed widths shared by the Go-Back-N sender window unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gbn_pkg;

  localparam int CMD_W     = 2;
  localparam int ACK_W     = 16;
  localparam int KIND_W    = 2;
  localparam int SEQ_OUT_W = 16;
  localparam int FLIGHT_W  = 6;
  localparam int WIN_CFG_W = 6;
  localparam int TOT_W     = 16;
  localparam int TMO_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int DUP_W     = 3;

  // input commands
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEND = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NEW    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESEND = 2'd2;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

  // config reset values
  localparam logic [WIN_CFG_W-1:0] WINDOW_RST  = 6'd30;
  localparam logic [TOT_W-1:0]     TOTAL_RST   = 16'd1;
  localparam logic [TMO_W-1:0]     TIMEOUT_RST = 16'd5000;

  // duplicate ACK counting
  localparam logic [DUP_W-1:0] DUP_ARM_PREV = 3'd2;  // third duplicate arms
  localparam logic [DUP_W-1:0] DUP_MAX      = 3'd7;

  typedef enum logic {
    ST_IDLE,
    ST_BURST
  } ctl_state_t;

  typedef struct packed {
    logic load_item;
    logic load_burst;
  } ctl_cmd_t;

  typedef struct packed {
    logic burst_start;
    logic burst_last;
  } dp_stat_t;

endpackage

`default_nettype wire

[sv/gbn_datapath.sv]
// ----------------------------------------------------------------------------
// gbn_datapath
// Window state, config registers, item evaluation, retransmit burst counter
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gbn_datapath #(
  parameter int WINDOW_MAX = 32,
  parameter int SEQ_BITS   = 16,
  parameter int TIMER_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [gbn_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [gbn_pkg::CFG_DAT_W-1:0]      cfg_data,
  input  wire logic [gbn_pkg::CMD_W-1:0]          cmd,
  input  wire logic [gbn_pkg::ACK_W-1:0]          ack_num,
  input  wire logic                               checksum_ok,
  input  wire gbn_pkg::ctl_cmd_t                  ctl,
  output gbn_pkg::dp_stat_t                       stat,
  output logic [gbn_pkg::KIND_W-1:0]              kind,
  output logic [gbn_pkg::SEQ_OUT_W-1:0]           seq_num,
  output logic [gbn_pkg::FLIGHT_W-1:0]            in_flight,
  output logic                                    transfer_done,
  output logic                                    last_result
);
  import gbn_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int SX    = SEQ_BITS + 1;
  localparam int AW    = (SEQ_BITS > ACK_W) ? SEQ_BITS : ACK_W;
  localparam int TW    = (TIMER_BITS > TMO_W) ? TIMER_BITS : TMO_W;

  // config
  logic [WIN_CFG_W-1:0]  window_size;
  logic [TOT_W-1:0]      message_total;
  logic [TMO_W-1:0]      timeout_ticks;

  // window state
  logic [SEQ_BITS-1:0]   window_base, window_base_next;
  logic [SEQ_BITS-1:0]   next_seq, next_seq_next;
  logic [ACK_W-1:0]      last_seen_ack, last_seen_ack_next;
  logic                  last_seen_valid, last_seen_valid_next;
  logic [DUP_W-1:0]      dup_count, dup_count_next;
  logic                  resend_armed, resend_armed_next;
  logic [TIMER_BITS-1:0] elapsed_ticks, elapsed_ticks_next;
  logic                  done_flag, done_flag_next;

  // burst
  logic [SEQ_BITS-1:0]   burst_seq, burst_seq_next;
  logic [CNT_W-1:0]      burst_left, burst_left_next;

  // first result of an item
  logic [KIND_W-1:0]     first_kind;
  logic [SEQ_BITS-1:0]   first_seq;
  logic                  first_last;

  logic                  send_ok;
  logic                  resend;
  logic [CNT_W-1:0]      w_eff;
  logic [SX-1:0]         win_limit;
  logic [SEQ_BITS-1:0]   diff;
  logic [CNT_W-1:0]      cnt_eff;

  always_comb begin
    window_base_next     = window_base;
    next_seq_next        = next_seq;
    last_seen_ack_next   = last_seen_ack;
    last_seen_valid_next = last_seen_valid;
    dup_count_next       = dup_count;
    resend_armed_next    = resend_armed;
    elapsed_ticks_next   = elapsed_ticks;
    done_flag_next       = done_flag;
    send_ok              = 1'b0;
    resend               = 1'b0;

    if (window_size == '0) begin
      w_eff = CNT_W'(1);
    end else if (int'(window_size) > WINDOW_MAX) begin
      w_eff = CNT_W'(WINDOW_MAX);
    end else begin
      w_eff = CNT_W'(window_size);
    end
    win_limit = SX'(window_base) + SX'(w_eff);

    if (!done_flag) begin
      unique case (cmd)
        CMD_ACK: begin
          if (checksum_ok) begin
            if (AW'(ack_num) >= AW'(window_base)) begin
              if (AW'(ack_num) >= AW'(next_seq)) begin
                window_base_next = next_seq;
              end else begin
                window_base_next = SEQ_BITS'(AW'(ack_num) + AW'(1));
              end
            end
            elapsed_ticks_next = '0;
            if (message_total != '0 && ack_num == message_total - TOT_W'(1)) begin
              done_flag_next = 1'b1;
            end else if (!last_seen_valid || last_seen_ack != ack_num) begin
              last_seen_ack_next   = ack_num;
              last_seen_valid_next = 1'b1;
              dup_count_next       = '0;
            end else if (dup_count != DUP_MAX) begin
              dup_count_next = dup_count + DUP_W'(1);
              if (dup_count == DUP_ARM_PREV) begin
                resend_armed_next = 1'b1;
              end
            end
          end
        end
        CMD_TICK: begin
          if (elapsed_ticks != '1) begin
            elapsed_ticks_next = elapsed_ticks + TIMER_BITS'(1);
          end
          resend = (TW'(elapsed_ticks_next) > TW'(timeout_ticks)) || resend_armed;
        end
        CMD_SEND: begin
          send_ok = (SX'(next_seq) < win_limit) &&
                    (AW'(next_seq) < AW'(message_total)) &&
                    (next_seq != '1);
          if (send_ok) begin
            if (window_base == next_seq) begin
              elapsed_ticks_next = '0;
            end
            next_seq_next = next_seq + SEQ_BITS'(1);
          end
          resend = (TW'(elapsed_ticks_next) > TW'(timeout_ticks)) || resend_armed;
        end
        default: begin
        end
      endcase
    end

    if (resend) begin
      elapsed_ticks_next = '0;
      resend_armed_next  = 1'b0;
    end

    diff = next_seq_next - window_base;
    if (!resend) begin
      cnt_eff = '0;
    end else if (diff > SEQ_BITS'(WINDOW_MAX)) begin
      cnt_eff = CNT_W'(WINDOW_MAX);
    end else begin
      cnt_eff = CNT_W'(diff);
    end

    // new packet first, then the resend burst; else one status result
    if (send_ok) begin
      first_kind      = KIND_NEW;
      first_seq       = next_seq;
      first_last      = (cnt_eff == '0);
      burst_seq_next  = window_base;
      burst_left_next = cnt_eff;
    end else if (cnt_eff != '0) begin
      first_kind      = KIND_RESEND;
      first_seq       = window_base;
      first_last      = (cnt_eff == CNT_W'(1));
      burst_seq_next  = window_base + SEQ_BITS'(1);
      burst_left_next = cnt_eff - CNT_W'(1);
    end else begin
      first_kind      = KIND_STATUS;
      first_seq       = '0;
      first_last      = 1'b1;
      burst_seq_next  = window_base;
      burst_left_next = '0;
    end
  end

  assign stat.burst_start = (burst_left_next != '0);
  assign stat.burst_last  = (burst_left == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size   <= WINDOW_RST;
      message_total <= TOTAL_RST;
      timeout_ticks <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW:  window_size   <= cfg_data[WIN_CFG_W-1:0];
        REG_TOTAL:   message_total <= cfg_data[TOT_W-1:0];
        REG_TIMEOUT: timeout_ticks <= cfg_data[TMO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_base     <= '0;
      next_seq        <= '0;
      last_seen_ack   <= '0;
      last_seen_valid <= 1'b0;
      dup_count       <= '0;
      resend_armed    <= 1'b0;
      elapsed_ticks   <= '0;
      done_flag       <= 1'b0;
      burst_left      <= '0;
    end else if (ctl.load_item) begin
      window_base     <= window_base_next;
      next_seq        <= next_seq_next;
      last_seen_ack   <= last_seen_ack_next;
      last_seen_valid <= last_seen_valid_next;
      dup_count       <= dup_count_next;
      resend_armed    <= resend_armed_next;
      elapsed_ticks   <= elapsed_ticks_next;
      done_flag       <= done_flag_next;
      burst_left      <= burst_left_next;
    end else if (ctl.load_burst) begin
      burst_left <= burst_left - CNT_W'(1);
    end
  end

  // output register and burst pointer
  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      kind          <= first_kind;
      seq_num       <= SEQ_OUT_W'(first_seq);
      in_flight     <= FLIGHT_W'(next_seq_next - window_base_next);
      transfer_done <= done_flag_next;
      last_result   <= first_last;
      burst_seq     <= burst_seq_next;
    end else if (ctl.load_burst) begin
      kind        <= KIND_RESEND;
      seq_num     <= SEQ_OUT_W'(burst_seq);
      last_result <= (burst_left == CNT_W'(1));
      burst_seq   <= burst_seq + SEQ_BITS'(1);
    end
  end

endmodule

`default_nettype wire

[sv/gbn_controller.sv]
// ----------------------------------------------------------------------------
// gbn_controller
// Sequencer for item intake and retransmit bursts; owns the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module gbn_controller (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire gbn_pkg::dp_stat_t stat,
  output gbn_pkg::ctl_cmd_t      ctl
);
  import gbn_pkg::*;

  ctl_state_t state, state_next;
  logic       out_valid_next;
  logic       slot_free;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    ctl.load_item  = 1'b0;
    ctl.load_burst = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready      = slot_free;
        ctl.load_item = in_valid && slot_free;
        if (ctl.load_item && stat.burst_start) begin
          state_next = ST_BURST;
        end
      end
      ST_BURST: begin
        ctl.load_burst = slot_free;
        if (slot_free && stat.burst_last) begin
          state_next = ST_IDLE;
        end
      end
    endcase

    if (ctl.load_item || ctl.load_burst) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

`default_nettype wire

[sv/go_back_n_sender_window_unit.sv]
// ----------------------------------------------------------------------------
// go_back_n_sender_window_unit
// Go-Back-N sender window with timeout and fast retransmit.
// Latency: the first result of an item is valid the cycle after it is taken.
// Throughput: one item per cycle when results are taken at once; an item
//   with several results holds off input until its resend burst is out, one
//   result per cycle when results are taken at once, out of the single output register and the burst counter.
// Reset: synchronous rst clears the window state and output valid, and loads
//   window 30, total 1, timeout 5000; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "go_back_n_sender_window_unit_defines.svh"

module go_back_n_sender_window_unit #(
  parameter int WINDOW_MAX = 32,
  parameter int SEQ_BITS   = 16,
  parameter int TIMER_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [gbn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gbn_pkg::CFG_DAT_W-1:0] cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [gbn_pkg::CMD_W-1:0]     cmd,
  input  wire logic [gbn_pkg::ACK_W-1:0]     ack_num,
  input  wire logic                          checksum_ok,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [gbn_pkg::KIND_W-1:0]         kind,
  output logic [gbn_pkg::SEQ_OUT_W-1:0]      seq_num,
  output logic [gbn_pkg::FLIGHT_W-1:0]       in_flight,
  output logic                               transfer_done,
  output logic                               last_result
);
  import gbn_pkg::*;

  ctl_cmd_t ctl;
  dp_stat_t stat;

  gbn_controller u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  gbn_datapath #(
    .WINDOW_MAX (WINDOW_MAX),
    .SEQ_BITS   (SEQ_BITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .ack_num       (ack_num),
    .checksum_ok   (checksum_ok),
    .ctl           (ctl),
    .stat          (stat),
    .kind          (kind),
    .seq_num       (seq_num),
    .in_flight     (in_flight),
    .transfer_done (transfer_done),
    .last_result   (last_result)
  );

  // an accepted item always produces a result next cycle
  `GBN_ASSERT_NEXT(a_item_gives_result, in_valid && in_ready, out_valid)
  // a taken result that is not last is followed by another
  `GBN_ASSERT_NEXT(a_burst_continues, out_valid && out_ready && !last_result, out_valid)
  // no new item while a burst is still pending
  `GBN_ASSERT_SAME(a_no_intake_in_burst, ctl.load_burst, !in_ready)
  // completion is sticky
  `GBN_ASSERT_NEXT(a_done_sticky, out_valid && transfer_done, !out_valid || transfer_done)

endmodule

`default_nettype wire

[bench/go_back_n_sender_window_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Go-Back-N sender window checker
// Watches the config port and both item channels, keeps its own copy of the
// window state, queues the results each accepted item should produce and
// compares every accepted result against the oldest one queued.
// ----------------------------------------------------------------------------
module go_back_n_sender_window_checker
  import gbn_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [CMD_W-1:0]     cmd,
  input  logic [ACK_W-1:0]     ack_num,
  input  logic                 checksum_ok,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [KIND_W-1:0]    kind,
  input  logic [SEQ_OUT_W-1:0] seq_num,
  input  logic [FLIGHT_W-1:0]  in_flight,
  input  logic                 transfer_done,
  input  logic                 last_result,
  output int                   fail_count,
  output int                   pending,
  output int                   checked,
  output int                   longest
);

  localparam int WINDOW_MAX = 32;
  localparam logic [SEQ_OUT_W-1:0] SEQ_TOP   = '1;
  localparam logic [TMO_W-1:0]     TIMER_TOP = '1;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [SEQ_OUT_W-1:0] seq;
    logic [FLIGHT_W-1:0]  flight;
    logic                 done;
    logic                 last;
  } window_result_t;

  logic [WIN_CFG_W-1:0] win_cfg;
  logic [TOT_W-1:0]     total_cfg;
  logic [TMO_W-1:0]     timeout_cfg;

  logic [SEQ_OUT_W-1:0] base;
  logic [SEQ_OUT_W-1:0] nxt;
  logic [ACK_W-1:0]     seen_ack;
  logic                 seen_valid;
  logic [DUP_W-1:0]     dups;
  logic                 armed;
  logic [TMO_W-1:0]     ticks;
  logic                 done;

  window_result_t results_due[$];
  window_result_t batch[$];

  function automatic window_result_t make_result(logic [KIND_W-1:0] k,
                                                 logic [SEQ_OUT_W-1:0] s);
    window_result_t r;
    logic [SEQ_OUT_W-1:0] diff;
    diff     = nxt - base;
    r.kind   = k;
    r.seq    = s;
    r.flight = diff[FLIGHT_W-1:0];
    r.done   = done;
    r.last   = 1'b0;
    return r;
  endfunction

  task automatic take_ack(input logic [ACK_W-1:0] a);
    int nb;
    if (a >= base) begin
      nb = int'(a) + 1;
      // never slide past what was actually sent
      if (nb > int'(nxt))
        nb = int'(nxt);
      base = SEQ_OUT_W'(nb);
    end
    ticks = '0;
    if (total_cfg != '0 && a == total_cfg - 16'd1) begin
      done = 1'b1;
    end else if (!seen_valid || seen_ack != a) begin
      seen_ack   = a;
      seen_valid = 1'b1;
      dups       = '0;
    end else if (dups < DUP_MAX) begin
      if (dups == DUP_ARM_PREV)
        armed = 1'b1;
      dups = dups + DUP_W'(1);
    end
  endtask

  task automatic advance_window(input logic [CMD_W-1:0] c, input logic [ACK_W-1:0] a,
                                input logic ok);
    int w;
    int cnt;
    batch.delete();
    if (done || (c != CMD_TICK && c != CMD_SEND)) begin
      if (!done && c == CMD_ACK && ok)
        take_ack(a);
      batch.push_back(make_result(KIND_STATUS, '0));
    end else begin
      if (c == CMD_TICK) begin
        if (ticks < TIMER_TOP)
          ticks = ticks + TMO_W'(1);
      end else begin
        w = int'(win_cfg);
        if (w < 1)
          w = 1;
        if (w > WINDOW_MAX)
          w = WINDOW_MAX;
        if (int'(nxt) < int'(base) + w && nxt < total_cfg && nxt < SEQ_TOP) begin
          if (base == nxt)
            ticks = '0;
          nxt = nxt + SEQ_OUT_W'(1);
          batch.push_back(make_result(KIND_NEW, nxt - SEQ_OUT_W'(1)));
        end
      end
      // timeout or fast retransmit: resend the outstanding window in order
      if (ticks > timeout_cfg || armed) begin
        cnt = int'(nxt - base);
        if (cnt > WINDOW_MAX)
          cnt = WINDOW_MAX;
        for (int i = 0; i < cnt; i++)
          batch.push_back(make_result(KIND_RESEND, base + SEQ_OUT_W'(i)));
        ticks = '0;
        armed = 1'b0;
      end
      if (batch.size() == 0)
        batch.push_back(make_result(KIND_STATUS, '0));
    end
    batch[batch.size() - 1].last = 1'b1;
    if (batch.size() > longest)
      longest = batch.size();
    foreach (batch[i])
      results_due.push_back(batch[i]);
  endtask

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    window_result_t front;
    if (rst) begin
      win_cfg     = WINDOW_RST;
      total_cfg   = TOTAL_RST;
      timeout_cfg = TIMEOUT_RST;
      base        = '0;
      nxt         = '0;
      seen_ack    = '0;
      seen_valid  = 1'b0;
      dups        = '0;
      armed       = 1'b0;
      ticks       = '0;
      done        = 1'b0;
      results_due.delete();
      fail_count  = 0;
      pending     = 0;
      checked     = 0;
      longest     = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW:  win_cfg = cfg_data[WIN_CFG_W-1:0];
          REG_TOTAL:   total_cfg = cfg_data[TOT_W-1:0];
          REG_TIMEOUT: timeout_cfg = cfg_data[TMO_W-1:0];
          default: ;
        endcase
      end
      // results first: an item taken at this edge cannot answer here
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: result with nothing expected, actual kind %0d seq %0d",
                   $time, kind, seq_num);
          fail_count++;
        end else begin
          front = results_due.pop_front();
          check_field("kind", front.kind, kind);
          check_field("seq_num", front.seq, seq_num);
          check_field("in_flight", front.flight, in_flight);
          check_field("transfer_done", front.done, transfer_done);
          check_field("last_result", front.last, last_result);
          checked++;
        end
      end
      if (in_valid && in_ready)
        advance_window(cmd, ack_num, checksum_ok);
      pending = results_due.size();
    end
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Go-Back-N sender window testbench
// Directed corner items, then four randomized phases of ticks, ACKs and send
// opportunities under different window settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module testbench;
  import gbn_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 70;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [CMD_W-1:0]     cmd;
  logic [ACK_W-1:0]     ack_num;
  logic                 checksum_ok;
  logic                 out_valid;
  logic                 out_ready;
  logic [KIND_W-1:0]    kind;
  logic [SEQ_OUT_W-1:0] seq_num;
  logic [FLIGHT_W-1:0]  in_flight;
  logic                 transfer_done;
  logic                 last_result;

  int fail_count;
  int pending;
  int checked;
  int longest;

  int send_idle;
  int recv_stall;
  int idle_cycles;
  int items_sent;
  int settings_used;
  int ack_mark;
  int sends_made;
  logic [TOT_W-1:0] total_now;
  logic allow_done;

  go_back_n_sender_window_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .ack_num       (ack_num),
    .checksum_ok   (checksum_ok),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .seq_num       (seq_num),
    .in_flight     (in_flight),
    .transfer_done (transfer_done),
    .last_result   (last_result)
  );

  go_back_n_sender_window_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .ack_num       (ack_num),
    .checksum_ok   (checksum_ok),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .seq_num       (seq_num),
    .in_flight     (in_flight),
    .transfer_done (transfer_done),
    .last_result   (last_result),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked       (checked),
    .longest       (longest)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= (recv_stall == 0) || ($urandom_range(99) >= recv_stall);
  end

  // ends the run if nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic push_item(input logic [CMD_W-1:0] c, input logic [ACK_W-1:0] a,
                           input logic ok);
    logic taken;
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= c;
    ack_num     <= a;
    checksum_ok <= ok;
    taken = 1'b0;
    // in_ready is stable by the falling edge, so it tells what the next edge does
    while (!taken) begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end
    items_sent++;
    if (c == CMD_SEND)
      sends_made++;
  endtask

  // hold the sender until every queued result has come out
  task automatic settle();
    in_valid <= 1'b0;
    do
      @(negedge clk);
    while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input logic [WIN_CFG_W-1:0] w, input logic [TOT_W-1:0] t,
                            input logic [TMO_W-1:0] tmo);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_WINDOW;
    cfg_data  <= CFG_DAT_W'(w);
    @(posedge clk);
    cfg_index <= REG_TOTAL;
    cfg_data  <= t;
    @(posedge clk);
    cfg_index <= REG_TIMEOUT;
    cfg_data  <= tmo;
    @(posedge clk);
    cfg_we    <= 1'b0;
    total_now = t;
    settings_used++;
  endtask

  task automatic random_item(input int send_pct, input int dup_pct);
    int roll;
    int pick;
    logic [ACK_W-1:0] a;
    roll = $urandom_range(99);
    if (roll < send_pct) begin
      push_item(CMD_SEND, ACK_W'($urandom), 1'($urandom));
    end else if (roll < send_pct + 15) begin
      push_item(CMD_TICK, ACK_W'($urandom), 1'($urandom));
    end else if (roll < 97) begin
      pick = $urandom_range(99);
      if (pick < dup_pct) begin
        a = ACK_W'(ack_mark);
      end else if (pick < dup_pct + (100 - dup_pct) / 2) begin
        // mostly cumulative ACKs within what has been offered for sending
        ack_mark = ack_mark + $urandom_range(4, 1);
        if (ack_mark > sends_made)
          ack_mark = sends_made;
        a = ACK_W'(ack_mark);
      end else if (pick < 95) begin
        a = ACK_W'($urandom_range(ack_mark));
      end else begin
        a = ACK_W'($urandom);
      end
      // keep the transfer open until the closing items
      if (!allow_done && total_now != '0 && a == total_now - 16'd1)
        a = a + ACK_W'(1);
      push_item(CMD_ACK, a, $urandom_range(9) != 0);
    end else begin
      push_item(CMD_SPARE, ACK_W'($urandom), 1'($urandom));
    end
  endtask

  task automatic run_phase(input logic [WIN_CFG_W-1:0] w, input logic [TOT_W-1:0] t,
                           input logic [TMO_W-1:0] tmo, input int idle_pct,
                           input int stall_pct, input int send_pct, input int dup_pct);
    write_regs(w, t, tmo);
    send_idle  = idle_pct;
    recv_stall = stall_pct;
    repeat (PHASE_ITEMS) begin
      if ($urandom_range(39) == 0)
        settle();
      random_item(send_pct, dup_pct);
    end
  endtask

  initial begin
    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_index   <= REG_WINDOW;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    cmd         <= CMD_TICK;
    ack_num     <= '0;
    checksum_ok <= 1'b0;
    out_ready   <= 1'b0;
    send_idle     = 0;
    recv_stall    = 0;
    items_sent    = 0;
    settings_used = 0;
    ack_mark      = 0;
    sends_made    = 0;
    total_now     = TOTAL_RST;
    allow_done    = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: window 30, total 1, timeout 5000
    push_item(CMD_SPARE, 16'hFFFF, 1'b1);
    push_item(CMD_TICK, 16'h0000, 1'b0);
    push_item(CMD_SEND, 16'h0000, 1'b0);
    push_item(CMD_SEND, 16'h0000, 1'b0);     // total already used up
    push_item(CMD_ACK, 16'h0000, 1'b0);      // final ACK, but bad checksum
    push_item(CMD_ACK, 16'd5, 1'b1);         // beyond what was sent
    repeat (3) push_item(CMD_ACK, 16'd5, 1'b1);
    push_item(CMD_TICK, 16'h0000, 1'b0);     // armed, window empty

    write_regs(6'd0, 16'd0, 16'd1);
    push_item(CMD_SEND, 16'h0000, 1'b1);     // zero total
    repeat (2) push_item(CMD_TICK, 16'h0000, 1'b0);

    write_regs(6'd0, 16'hFFFF, 16'd1);
    repeat (2) push_item(CMD_SEND, 16'h0000, 1'b0);
    repeat (2) push_item(CMD_TICK, 16'h0000, 1'b0);
    push_item(CMD_ACK, 16'd0, 1'b1);         // below base, still restarts timer
    push_item(CMD_ACK, 16'd1, 1'b1);
    ack_mark = 1;

    run_phase(6'd4, 16'd40, 16'd3, 0, 0, 45, 40);
    run_phase(6'd63, 16'd200, 16'hFFFF, 82, 0, 60, 70);
    run_phase(6'd32, 16'd300, 16'd1, 0, 82, 45, 30);
    run_phase(6'd7, 16'hFFFF, 16'd10, 27, 27, 45, 40);

    allow_done = 1'b1;
    push_item(CMD_ACK, total_now - 16'd1, 1'b1);
    push_item(CMD_TICK, 16'h0000, 1'b0);
    push_item(CMD_SEND, 16'h0000, 1'b0);
    push_item(CMD_ACK, 16'h0000, 1'b1);
    settle();

    $display("Drove %0d items across %0d register settings and four idle/stall mixes",
             items_sent, settings_used + 1);
    $display("Checked %0d results; longest burst from one item: %0d", checked, longest);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/gbn_pkg.sv
sv/gbn_datapath.sv
sv/gbn_controller.sv
sv/go_back_n_sender_window_unit.sv
bench/go_back_n_sender_window_checker.sv
bench/testbench.sv
